@@ rtl/sosg_pkg.sv @@
// ----------------------------------------------------------------------------
// sosg_pkg
// Shared types, codes and fixed-point helpers of the shape outline generator.
// ----------------------------------------------------------------------------
package sosg_pkg;

   typedef enum logic [1:0] {
      KIND_CIRCLE = 2'd0,
      KIND_BOX    = 2'd1,
      KIND_OBOX   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CSR_DRAW_ENABLE  = 1'd0,
      CSR_PLANE_HEIGHT = 1'd1
   } csr_index_type;

   localparam logic [31:0] PLANE_HEIGHT_RESET = 32'd3277;
   localparam int          TERM_W             = 34;
   localparam int          SUM_W              = 36;
   localparam int          QUEUE_DEPTH        = 2;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] Q30_ONE = 64'h0000_0000_4000_0000;

   localparam logic signed [SUM_W-1:0] SAT_MAX = 36'sh07FFFFFFF;
   localparam logic signed [SUM_W-1:0] SAT_MIN = 36'shF80000000;

   typedef logic signed [TERM_W-1:0] term_type;

   // One classified command; offsets ax..bz are already scaled
   typedef struct packed {
      kind_type           kind;
      logic [31:0]        color;
      logic signed [31:0] cx;
      logic signed [31:0] cz;
      term_type           ax;
      term_type           az;
      term_type           bx;
      term_type           bz;
   } shape_type;

   function automatic logic [63:0] rnd30(input logic [63:0] v);
      return (v + 64'h2000_0000) >> 30;
   endfunction

   function automatic logic [63:0] rnd31(input logic [63:0] v);
      return (v + 64'h4000_0000) >> 31;
   endfunction

   // Q2.30 cos/sin of a turn fraction; evaluated at elaboration only
   function automatic logic [63:0] unit_vec(input logic [31:0] phase);
      logic [63:0] r, x, x2, x3, x4, x5, x6, x7, x8, s, c, t, co, si;
      logic        swap;
      r    = 64'(phase[29:0]);
      swap = r > 64'h2000_0000;
      if (swap) begin
         r = Q30_ONE - r;
      end
      x  = rnd31(r * PI_Q30);
      x2 = rnd30(x * x);
      x3 = rnd30(x2 * x);
      x4 = rnd30(x2 * x2);
      x5 = rnd30(x4 * x);
      x6 = rnd30(x4 * x2);
      x7 = rnd30(x6 * x);
      x8 = rnd30(x4 * x4);
      s  = ((x - x3 / 64'd6) + x5 / 64'd120) - x7 / 64'd5040;
      c  = (((Q30_ONE - x2 / 64'd2) + x4 / 64'd24) - x6 / 64'd720) + x8 / 64'd40320;
      if (swap) begin
         t = s;
         s = c;
         c = t;
      end
      case (phase[31:30])
         2'd0: begin
            co = c;
            si = s;
         end
         2'd1: begin
            co = -s;
            si = c;
         end
         2'd2: begin
            co = -c;
            si = -s;
         end
         default: begin
            co = s;
            si = -c;
         end
      endcase
      return {co[31:0], si[31:0]};
   endfunction

   // product >> 30, rounded half away from zero
   function automatic term_type round_q30(input logic signed [63:0] p);
      logic [63:0] mag, r;
      mag = p[63] ? 64'(-p) : 64'(p);
      r   = (mag + 64'h2000_0000) >> 30;
      return p[63] ? -$signed(r[TERM_W-1:0]) : $signed(r[TERM_W-1:0]);
   endfunction

   // product >> 14, rounded half away from zero
   function automatic term_type round_q14(input logic signed [47:0] p);
      logic [47:0] mag, r;
      mag = p[47] ? 48'(-p) : 48'(p);
      r   = (mag + 48'h2000) >> 14;
      return p[47] ? -$signed(r[TERM_W-1:0]) : $signed(r[TERM_W-1:0]);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      if (v > SAT_MAX) begin
         return 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

@@ rtl/sosg_front.sv @@
// ----------------------------------------------------------------------------
// sosg_front
// Accepts shape commands, drops empty or disabled ones and scales box axes.
// ----------------------------------------------------------------------------
module sosg_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      draw_enable,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_shape_kind,
   input  logic signed [31:0]        req_center_x,
   input  logic signed [31:0]        req_center_z,
   input  logic [30:0]               req_radius,
   input  logic [30:0]               req_half_x,
   input  logic [30:0]               req_half_z,
   input  logic signed [15:0]        req_axis_a_x,
   input  logic signed [15:0]        req_axis_a_z,
   input  logic signed [15:0]        req_axis_b_x,
   input  logic signed [15:0]        req_axis_b_z,
   input  logic [31:0]               req_rgba,
   input  logic                      q_full,
   output logic                      q_push,
   output sosg_pkg::shape_type       q_data
);
   import sosg_pkg::*;

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        color;
      logic signed [31:0] cx;
      logic signed [31:0] cz;
      logic [30:0]        radius;
      logic [30:0]        hx;
      logic [30:0]        hz;
      logic signed [15:0] aax;
      logic signed [15:0] aaz;
      logic signed [15:0] abx;
      logic signed [15:0] abz;
   } s1_type;

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        color;
      logic signed [31:0] cx;
      logic signed [31:0] cz;
      logic [30:0]        radius;
      logic [30:0]        hx;
      logic [30:0]        hz;
      logic signed [47:0] pax;
      logic signed [47:0] paz;
      logic signed [47:0] pbx;
      logic signed [47:0] pbz;
   } s2_type;

   logic   s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   logic   s2_free, accept, keep;

   assign s2_free   = !s2_v_ff || !q_full;
   assign req_ready = !s1_v_ff || s2_free;
   assign accept    = req_valid && req_ready;
   assign keep      = draw_enable && (kind_type'(req_shape_kind) != KIND_NONE);
   assign q_push    = s2_v_ff && !q_full;

   always_comb begin
      s1_v_in       = req_ready ? (accept && keep) : s1_v_ff;
      s1_in.kind    = kind_type'(req_shape_kind);
      s1_in.color   = req_rgba;
      s1_in.cx      = req_center_x;
      s1_in.cz      = req_center_z;
      s1_in.radius  = req_radius;
      s1_in.hx      = req_half_x;
      s1_in.hz      = req_half_z;
      s1_in.aax     = req_axis_a_x;
      s1_in.aaz     = req_axis_a_z;
      s1_in.abx     = req_axis_b_x;
      s1_in.abz     = req_axis_b_z;

      s2_v_in       = s2_free ? s1_v_ff : s2_v_ff;
      s2_in.kind    = s1_ff.kind;
      s2_in.color   = s1_ff.color;
      s2_in.cx      = s1_ff.cx;
      s2_in.cz      = s1_ff.cz;
      s2_in.radius  = s1_ff.radius;
      s2_in.hx      = s1_ff.hx;
      s2_in.hz      = s1_ff.hz;
      s2_in.pax     = s1_ff.aax * $signed({1'b0, s1_ff.hx});
      s2_in.paz     = s1_ff.aaz * $signed({1'b0, s1_ff.hx});
      s2_in.pbx     = s1_ff.abx * $signed({1'b0, s1_ff.hz});
      s2_in.pbz     = s1_ff.abz * $signed({1'b0, s1_ff.hz});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s2_free && s1_v_ff) begin
         s2_ff <= s2_in;
      end
   end

   always_comb begin
      q_data.kind  = s2_ff.kind;
      q_data.color = s2_ff.color;
      q_data.cx    = s2_ff.cx;
      q_data.cz    = s2_ff.cz;
      unique case (s2_ff.kind)
         KIND_CIRCLE: begin
            q_data.ax = TERM_W'(s2_ff.radius);
            q_data.az = '0;
            q_data.bx = '0;
            q_data.bz = '0;
         end
         KIND_BOX: begin
            q_data.ax = TERM_W'(s2_ff.hx);
            q_data.az = '0;
            q_data.bx = '0;
            q_data.bz = TERM_W'(s2_ff.hz);
         end
         KIND_OBOX: begin
            q_data.ax = round_q14(s2_ff.pax);
            q_data.az = round_q14(s2_ff.paz);
            q_data.bx = round_q14(s2_ff.pbx);
            q_data.bz = round_q14(s2_ff.pbz);
         end
         default: begin
            q_data.ax = '0;
            q_data.az = '0;
            q_data.bx = '0;
            q_data.bz = '0;
         end
      endcase
   end

endmodule

@@ rtl/sosg_queue.sv @@
// ----------------------------------------------------------------------------
// sosg_queue
// Short command queue between the front and the segment sequencer.
// ----------------------------------------------------------------------------
module sosg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sosg_pkg::shape_type wr_data,
   input  logic                pop,
   output sosg_pkg::shape_type rd_data,
   output logic                full,
   output logic                empty
);
   import sosg_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   shape_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

@@ rtl/sosg_back.sv @@
// ----------------------------------------------------------------------------
// sosg_back
// Walks the outline points of the head command and emits one segment per
// point after the first.
// ----------------------------------------------------------------------------
module sosg_back #(
   parameter int CIRCLE_SEGMENTS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  sosg_pkg::shape_type q_data,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_start_x,
   output logic signed [31:0]  rsp_start_z,
   output logic signed [31:0]  rsp_end_x,
   output logic signed [31:0]  rsp_end_z,
   output logic [31:0]         rsp_segment_color,
   output logic                rsp_last_segment
);
   import sosg_pkg::*;

   localparam int CNT_MAX = (CIRCLE_SEGMENTS > 4) ? CIRCLE_SEGMENTS : 4;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam int TAB_W   = $clog2(CIRCLE_SEGMENTS + 1);

   typedef struct packed {
      logic               first;
      logic               last;
      logic               circ;
      logic [31:0]        color;
      logic signed [31:0] cx;
      logic signed [31:0] cz;
      logic signed [63:0] px;
      logic signed [63:0] pz;
      term_type           tx1;
      term_type           tx2;
      term_type           tz1;
      term_type           tz2;
   } b1_type;

   typedef struct packed {
      logic               first;
      logic               last;
      logic [31:0]        color;
      logic signed [31:0] cx;
      logic signed [31:0] cz;
      term_type           ox1;
      term_type           ox2;
      term_type           oz1;
      term_type           oz2;
   } b2_type;

   typedef struct packed {
      logic               first;
      logic               last;
      logic [31:0]        color;
      logic signed [31:0] x;
      logic signed [31:0] z;
   } b3_type;

   logic signed [31:0] cos_tab [0:CIRCLE_SEGMENTS];
   logic signed [31:0] sin_tab [0:CIRCLE_SEGMENTS];

   for (genvar g = 0; g <= CIRCLE_SEGMENTS; g++) begin : g_tab
      localparam logic [63:0] NUM   = (64'(g) << 32) + 64'(CIRCLE_SEGMENTS / 2);
      localparam logic [31:0] PHASE = 32'(NUM / CIRCLE_SEGMENTS);
      localparam logic [63:0] CS    = unit_vec(PHASE);
      assign cos_tab[g] = CS[63:32];
      assign sin_tab[g] = CS[31:0];
   end

   logic               adv, issue, is_circ, sa_neg, sb_neg;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, last_pt;
   logic [1:0]         corner;
   logic [TAB_W-1:0]   tab_idx;
   logic               b1_v_ff, b2_v_ff, b3_v_ff, rsp_v_ff, rsp_v_in;
   b1_type             b1_ff, b1_in;
   b2_type             b2_ff, b2_in;
   b3_type             b3_ff, b3_in;
   logic signed [31:0] prev_x_ff, prev_z_ff;
   logic signed [31:0] out_sx_ff, out_sz_ff, out_ex_ff, out_ez_ff;
   logic [31:0]        out_color_ff;
   logic               out_last_ff;

   assign adv     = !(rsp_v_ff && !rsp_ready);
   assign issue   = adv && !q_empty;
   assign is_circ = q_data.kind == KIND_CIRCLE;
   assign last_pt = is_circ ? CNT_W'(CIRCLE_SEGMENTS) : CNT_W'(4);
   assign q_pop   = issue && (cnt_ff == last_pt);
   assign tab_idx = cnt_ff[TAB_W-1:0];
   assign corner  = (cnt_ff == CNT_W'(4)) ? 2'd0 : cnt_ff[1:0];
   assign sa_neg  = (corner == 2'd1) || (corner == 2'd2);
   assign sb_neg  = (corner == 2'd2) || (corner == 2'd3);
   assign rsp_v_in = b3_v_ff && !b3_ff.first;

   always_comb begin
      cnt_in = cnt_ff;
      if (issue) begin
         cnt_in = q_pop ? '0 : cnt_ff + 1'b1;
      end

      b1_in.first = cnt_ff == '0;
      b1_in.last  = cnt_ff == last_pt;
      b1_in.circ  = is_circ;
      b1_in.color = q_data.color;
      b1_in.cx    = q_data.cx;
      b1_in.cz    = q_data.cz;
      b1_in.px    = $signed({1'b0, q_data.ax[30:0]}) * cos_tab[tab_idx];
      b1_in.pz    = $signed({1'b0, q_data.ax[30:0]}) * sin_tab[tab_idx];
      b1_in.tx1   = sa_neg ? -q_data.ax : q_data.ax;
      b1_in.tz1   = sa_neg ? -q_data.az : q_data.az;
      b1_in.tx2   = sb_neg ? -q_data.bx : q_data.bx;
      b1_in.tz2   = sb_neg ? -q_data.bz : q_data.bz;

      b2_in.first = b1_ff.first;
      b2_in.last  = b1_ff.last;
      b2_in.color = b1_ff.color;
      b2_in.cx    = b1_ff.cx;
      b2_in.cz    = b1_ff.cz;
      b2_in.ox1   = b1_ff.circ ? round_q30(b1_ff.px) : b1_ff.tx1;
      b2_in.oz1   = b1_ff.circ ? round_q30(b1_ff.pz) : b1_ff.tz1;
      b2_in.ox2   = b1_ff.circ ? term_type'(0) : b1_ff.tx2;
      b2_in.oz2   = b1_ff.circ ? term_type'(0) : b1_ff.tz2;

      b3_in.first = b2_ff.first;
      b3_in.last  = b2_ff.last;
      b3_in.color = b2_ff.color;
      b3_in.x     = sat32(SUM_W'(b2_ff.cx) + SUM_W'(b2_ff.ox1) + SUM_W'(b2_ff.ox2));
      b3_in.z     = sat32(SUM_W'(b2_ff.cz) + SUM_W'(b2_ff.oz1) + SUM_W'(b2_ff.oz2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         b1_v_ff  <= 1'b0;
         b2_v_ff  <= 1'b0;
         b3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         cnt_ff   <= cnt_in;
         b1_v_ff  <= issue;
         b2_v_ff  <= b1_v_ff;
         b3_v_ff  <= b2_v_ff;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         b3_ff <= b3_in;
         if (b3_v_ff) begin
            prev_x_ff    <= b3_ff.x;
            prev_z_ff    <= b3_ff.z;
            out_sx_ff    <= prev_x_ff;
            out_sz_ff    <= prev_z_ff;
            out_ex_ff    <= b3_ff.x;
            out_ez_ff    <= b3_ff.z;
            out_color_ff <= b3_ff.color;
            out_last_ff  <= b3_ff.last;
         end
      end
   end

   assign rsp_valid         = rsp_v_ff;
   assign rsp_start_x       = out_sx_ff;
   assign rsp_start_z       = out_sz_ff;
   assign rsp_end_x         = out_ex_ff;
   assign rsp_end_z         = out_ez_ff;
   assign rsp_segment_color = out_color_ff;
   assign rsp_last_segment  = out_last_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> cnt_ff <= last_pt)
      else $error("point counter past last point");

   a_first_no_seg: assert property (@(posedge clock) disable iff (reset)
      (adv && b3_v_ff && b3_ff.first) |=> !rsp_v_ff)
      else $error("segment emitted for opening point");

endmodule

@@ rtl/shape_outline_segment_generator_core.sv @@
// ----------------------------------------------------------------------------
// shape_outline_segment_generator_core
// Turns circle and box commands into outline segments on a fixed-height plane.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  req     | req_valid / req_ready  | one shape command
//  rsp     | rsp_valid / rsp_ready  | one segment, rsp_last_segment closes shape
//  csr     | csr_we                 | csr_index selects register, csr_wdata
//
//  The point sequencer issues a circle's CIRCLE_SEGMENTS + 1 outline points or
//  a box's 5, one per cycle unless the queue is empty or rsp is stalled.
//  Data passes s1, s2, the queue, b1, b2, b3 and the output registers. Reset
//  is synchronous; draw_enable comes up 1 and plane_height 3277. A stalled rsp
//  freezes the sequencer; the two-entry queue lets req take commands meanwhile.
// ----------------------------------------------------------------------------
module shape_outline_segment_generator_core #(
   parameter int CIRCLE_SEGMENTS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_shape_kind,
   input  logic signed [31:0]            req_center_x,
   input  logic signed [31:0]            req_center_z,
   input  logic [30:0]                   req_radius,
   input  logic [30:0]                   req_half_x,
   input  logic [30:0]                   req_half_z,
   input  logic signed [15:0]            req_axis_a_x,
   input  logic signed [15:0]            req_axis_a_z,
   input  logic signed [15:0]            req_axis_b_x,
   input  logic signed [15:0]            req_axis_b_z,
   input  logic [31:0]                   req_rgba,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_start_x,
   output logic signed [31:0]            rsp_start_z,
   output logic signed [31:0]            rsp_end_x,
   output logic signed [31:0]            rsp_end_z,
   output logic signed [31:0]            rsp_height,
   output logic [31:0]                   rsp_segment_color,
   output logic                          rsp_last_segment,
   input  logic                          csr_we,
   input  sosg_pkg::csr_index_type       csr_index,
   input  logic [31:0]                   csr_wdata
);
   import sosg_pkg::*;

   logic        draw_enable_ff, draw_enable_in;
   logic [31:0] plane_height_ff, plane_height_in;
   logic        q_push, q_pop, q_full, q_empty;
   shape_type   q_wr, q_rd;

   always_comb begin
      draw_enable_in  = draw_enable_ff;
      plane_height_in = plane_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DRAW_ENABLE:  draw_enable_in  = csr_wdata[0];
            CSR_PLANE_HEIGHT: plane_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_enable_ff  <= 1'b1;
         plane_height_ff <= PLANE_HEIGHT_RESET;
      end else begin
         draw_enable_ff  <= draw_enable_in;
         plane_height_ff <= plane_height_in;
      end
   end

   assign rsp_height = plane_height_ff;

   sosg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .draw_enable    (draw_enable_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_shape_kind (req_shape_kind),
      .req_center_x   (req_center_x),
      .req_center_z   (req_center_z),
      .req_radius     (req_radius),
      .req_half_x     (req_half_x),
      .req_half_z     (req_half_z),
      .req_axis_a_x   (req_axis_a_x),
      .req_axis_a_z   (req_axis_a_z),
      .req_axis_b_x   (req_axis_b_x),
      .req_axis_b_z   (req_axis_b_z),
      .req_rgba       (req_rgba),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_wr)
   );

   sosg_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr),
      .pop     (q_pop),
      .rd_data (q_rd),
      .full    (q_full),
      .empty   (q_empty)
   );

   sosg_back #(
      .CIRCLE_SEGMENTS (CIRCLE_SEGMENTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_data            (q_rd),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_start_x       (rsp_start_x),
      .rsp_start_z       (rsp_start_z),
      .rsp_end_x         (rsp_end_x),
      .rsp_end_z         (rsp_end_z),
      .rsp_segment_color (rsp_segment_color),
      .rsp_last_segment  (rsp_last_segment)
   );

endmodule
